/* rtl/core/assert_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while rst is high.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, gated off while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/tgsp_pkg.sv */
package tgsp_pkg;

   localparam int CODE_W     = 8;
   localparam int ROW_W      = 3;
   localparam int SCAN_W     = 4;
   localparam int MARGIN_W   = 4;
   localparam int HEIGHT_W   = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [MARGIN_W-1:0] TOP_MARGIN_RESET  = 4'd3;
   localparam logic [HEIGHT_W-1:0] CELL_HEIGHT_RESET = 5'd14;

   // Register selects, taken from paddr[2]
   localparam logic REG_TOP_MARGIN  = 1'b0;
   localparam logic REG_CELL_HEIGHT = 1'b1;

   typedef enum logic {
      CMD_FONT_WRITE = 1'b0,
      CMD_RENDER     = 1'b1
   } cmd_type;

   typedef struct packed {
      logic blank;
      logic last;
   } render_info_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       last_of_item;
      logic       end_of_scanline;
   } beat_type;

endpackage

/* rtl/core/tgsp_ram.sv */
module tgsp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tgsp_lookup.sv */
module tgsp_lookup #(
   parameter int FONT_CHARS = 256,
   parameter int GLYPH_ROWS = 8,
   parameter int ADDR_W     = $clog2(FONT_CHARS * GLYPH_ROWS)
) (
   input  logic                            accept,
   input  logic                            cmd,
   input  logic [tgsp_pkg::CODE_W-1:0]     char_code,
   input  logic [tgsp_pkg::ROW_W-1:0]      glyph_row,
   input  logic [tgsp_pkg::SCAN_W-1:0]     scan_row,
   input  logic                            last_in_scanline,
   input  logic [tgsp_pkg::MARGIN_W-1:0]   top_margin,
   input  logic [tgsp_pkg::HEIGHT_W-1:0]   cell_height,
   output logic                            wr_en,
   output logic [ADDR_W-1:0]               wr_addr,
   output logic                            rd_en,
   output logic [ADDR_W-1:0]               rd_addr,
   output tgsp_pkg::render_info_type       info
);

   localparam logic [ADDR_W-1:0]             ROWS_A  = ADDR_W'(GLYPH_ROWS);
   localparam logic [tgsp_pkg::CODE_W:0]     CHARS_C = (tgsp_pkg::CODE_W + 1)'(FONT_CHARS);
   localparam logic [tgsp_pkg::SCAN_W:0]     ROWS_S  = (tgsp_pkg::SCAN_W + 1)'(GLYPH_ROWS);

   logic [tgsp_pkg::SCAN_W:0] offset;
   logic [ADDR_W-1:0]         char_base;
   logic                      code_ok;
   logic                      row_ok;

   assign char_base = ADDR_W'(char_code) * ROWS_A;
   assign code_ok   = {1'b0, char_code} < CHARS_C;

   // Top bit set means the scanline lies in the top margin
   assign offset = {1'b0, scan_row} - {1'b0, top_margin};
   assign row_ok = !offset[tgsp_pkg::SCAN_W]
                   && ({1'b0, offset[tgsp_pkg::SCAN_W-1:0]} < ROWS_S)
                   && ({1'b0, scan_row} < cell_height);

   assign wr_en   = accept && (cmd == tgsp_pkg::CMD_FONT_WRITE) && code_ok
                    && ({2'b00, glyph_row} < ROWS_S);
   assign wr_addr = char_base + ADDR_W'(glyph_row);

   assign rd_en   = accept && (cmd == tgsp_pkg::CMD_RENDER);
   assign rd_addr = char_base + ADDR_W'(offset[tgsp_pkg::SCAN_W-1:0]);

   assign info.blank = !(code_ok && row_ok);
   assign info.last  = last_in_scanline;

endmodule

/* rtl/core/tgsp_packer.sv */
module tgsp_packer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  tgsp_pkg::render_info_type   load_info,
   input  logic [7:0]                  glyph_data,
   output logic                        take_ready,
   input  logic                        out_ready,
   output logic                        out_valid,
   output tgsp_pkg::beat_type          out_beat
);

   logic                        s1_valid_ff, s1_valid_in;
   tgsp_pkg::render_info_type   s1_info_ff;
   logic [7:0]                  acc_ff, acc_in;
   logic [2:0]                  pend_ff, pend_in;
   logic                        o0_valid_ff, o0_valid_in;
   logic                        o1_valid_ff, o1_valid_in;
   tgsp_pkg::beat_type          o0_ff, o0_in;
   tgsp_pkg::beat_type          o1_ff, o1_in;

   logic [7:0]          glyph;
   logic [16:0]         stream;
   logic [3:0]          shift0;
   logic                two_beats;
   logic                pop;
   logic                advance;
   tgsp_pkg::beat_type  beat0, beat1;

   // Pending bits sit in the low end of acc_ff, ahead of the blank pixel
   assign glyph     = s1_info_ff.blank ? 8'h00 : glyph_data;
   assign stream    = {acc_ff, 1'b0, glyph};
   assign shift0    = {1'b0, pend_ff} + 4'd1;
   assign two_beats = (pend_ff == 3'd7) || s1_info_ff.last;

   always_comb begin
      beat0.pixel_byte      = 8'(stream >> shift0);
      beat0.last_of_item    = !two_beats;
      beat0.end_of_scanline = 1'b0;
      // Either a second full byte or the flush, padded on the right
      beat1.pixel_byte      = 8'(glyph << (3'd7 - pend_ff));
      beat1.last_of_item    = 1'b1;
      beat1.end_of_scanline = s1_info_ff.last;
   end

   assign pop     = o0_valid_ff && out_ready;
   assign advance = s1_valid_ff && (!o0_valid_ff || (pop && !o1_valid_ff));

   always_comb begin
      s1_valid_in = s1_valid_ff;
      acc_in      = acc_ff;
      pend_in     = pend_ff;
      o0_valid_in = o0_valid_ff;
      o1_valid_in = o1_valid_ff;
      o0_in       = o0_ff;
      o1_in       = o1_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
         acc_in      = glyph;
         pend_in     = two_beats ? 3'd0 : pend_ff + 3'd1;
         o0_valid_in = 1'b1;
         o0_in       = beat0;
         o1_valid_in = two_beats;
         o1_in       = beat1;
      end else if (pop) begin
         o0_valid_in = o1_valid_ff;
         o0_in       = o1_ff;
         o1_valid_in = 1'b0;
      end
      if (load) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         acc_ff      <= 8'h00;
         pend_ff     <= 3'd0;
         o0_valid_ff <= 1'b0;
         o1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         acc_ff      <= acc_in;
         pend_ff     <= pend_in;
         o0_valid_ff <= o0_valid_in;
         o1_valid_ff <= o1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      o0_ff <= o0_in;
      o1_ff <= o1_in;
      if (load) begin
         s1_info_ff <= load_info;
      end
   end

   // Hold new items while the stage owns the read data and cannot move
   assign take_ready = !s1_valid_ff || advance;
   assign out_valid  = o0_valid_ff;
   assign out_beat   = o0_ff;

endmodule

/* rtl/core/text_glyph_scanline_packer_core.sv */
// Text-mode character generator with a 9-dot cell.
// req channel: cmd selects a font write (stores font_byte at char_code,
//   glyph_row) or a render of char_code on scan_row; last_in_scanline
//   marks the final character of a scanline and flushes leftover bits.
// rsp channel: packed pixel bytes, MSB leftmost; last_of_item flags the
//   final beat of a render, end_of_scanline the final beat of a line.
// csr: APB-style; top_margin at 0x0, cell_height at 0x4; pready is tied high.
// Order: an accepted render is read from the font memory into a register,
//   then packed into the output buffer, which offers its first beat.
// Throughput: one item per cycle while rsp_ready is high, except that a render
//   that gives two beats (seven bits already pending, or the end of a line)
//   holds back the next item while its second beat waits; the single output
//   beat per cycle sets this limit. Font writes produce no beat.
// Reset: pending bits and the output buffer clear, top_margin returns to 3
//   and cell_height to 14; font contents are undefined until written.
// Stall: with rsp_ready low the output buffer and the render stage fill,
//   and req_ready stays low until the render stage can move on.
module text_glyph_scanline_packer_core #(
   parameter int FONT_CHARS = 256,
   parameter int GLYPH_ROWS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [tgsp_pkg::CODE_W-1:0]         req_char_code,
   input  logic [tgsp_pkg::ROW_W-1:0]          req_glyph_row,
   input  logic [7:0]                          req_font_byte,
   input  logic [tgsp_pkg::SCAN_W-1:0]         req_scan_row,
   input  logic                                req_last_in_scanline,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_pixel_byte,
   output logic                                rsp_last_of_item,
   output logic                                rsp_end_of_scanline,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tgsp_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tgsp_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tgsp_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int FONT_DEPTH = FONT_CHARS * GLYPH_ROWS;
   localparam int ADDR_W     = $clog2(FONT_DEPTH);

   logic [tgsp_pkg::MARGIN_W-1:0] top_margin_ff, top_margin_in;
   logic [tgsp_pkg::HEIGHT_W-1:0] cell_height_ff, cell_height_in;

   logic                       accept;
   logic                       csr_write;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [7:0]                 rd_data;
   tgsp_pkg::render_info_type  info;
   tgsp_pkg::beat_type         beat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      top_margin_in  = top_margin_ff;
      cell_height_in = cell_height_ff;
      if (csr_write) begin
         if (paddr[2] == tgsp_pkg::REG_TOP_MARGIN) begin
            top_margin_in = pwdata[tgsp_pkg::MARGIN_W-1:0];
         end else begin
            cell_height_in = pwdata[tgsp_pkg::HEIGHT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_margin_ff  <= tgsp_pkg::TOP_MARGIN_RESET;
         cell_height_ff <= tgsp_pkg::CELL_HEIGHT_RESET;
      end else begin
         top_margin_ff  <= top_margin_in;
         cell_height_ff <= cell_height_in;
      end
   end

   assign prdata = (paddr[2] == tgsp_pkg::REG_CELL_HEIGHT)
                   ? tgsp_pkg::CSR_DATA_W'(cell_height_ff)
                   : tgsp_pkg::CSR_DATA_W'(top_margin_ff);

   assign accept = req_valid && req_ready;

   tgsp_lookup #(
      .FONT_CHARS (FONT_CHARS),
      .GLYPH_ROWS (GLYPH_ROWS),
      .ADDR_W     (ADDR_W)
   ) u_lookup (
      .accept           (accept),
      .cmd              (req_cmd),
      .char_code        (req_char_code),
      .glyph_row        (req_glyph_row),
      .scan_row         (req_scan_row),
      .last_in_scanline (req_last_in_scanline),
      .top_margin       (top_margin_ff),
      .cell_height      (cell_height_ff),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .info             (info)
   );

   tgsp_ram #(
      .WIDTH  (8),
      .DEPTH  (FONT_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_font (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_font_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tgsp_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .load       (rd_en),
      .load_info  (info),
      .glyph_data (rd_data),
      .take_ready (req_ready),
      .out_ready  (rsp_ready),
      .out_valid  (rsp_valid),
      .out_beat   (beat)
   );

   assign rsp_pixel_byte      = beat.pixel_byte;
   assign rsp_last_of_item    = beat.last_of_item;
   assign rsp_end_of_scanline = beat.end_of_scanline;

endmodule

/* rtl/core/tgsp_checker.sv */
`include "assert_macros.svh"

module tgsp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_byte,
   input logic       rsp_last_of_item,
   input logic       rsp_end_of_scanline
);

   logic [9:0] rsp_payload;
   logic       rsp_stall;
   logic       rsp_take;

   assign rsp_payload = {rsp_pixel_byte, rsp_last_of_item, rsp_end_of_scanline};
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_take    = rsp_valid && rsp_ready;

   // A stalled beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   // End of line is always the closing beat of its render
   `ASSERT_NOW(a_eol_closes_item, clock, reset, rsp_valid && rsp_end_of_scanline, rsp_last_of_item)

   // The second beat of a render follows its first without a gap
   `ASSERT_NEXT(a_second_beat_ready, clock, reset, rsp_take && !rsp_last_of_item, rsp_valid)

   // Out of reset the block is empty and open
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind text_glyph_scanline_packer_core tgsp_checker u_checker (.*);
